>>> rtl/tlb_fifo_lru_page_tracker_defines.svh
// assertion macros for the tlb page tracker
`ifndef TLB_FIFO_LRU_PAGE_TRACKER_DEFINES_SVH
`define TLB_FIFO_LRU_PAGE_TRACKER_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while in reset
`define TLBPT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off while in reset
`define TLBPT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tlbpt_pkg.sv
// shared constants, types and functions of the tlb page tracker
package tlbpt_pkg;

  localparam int TLB_ENTRIES   = 16;
  localparam int PAGE_COUNT    = 256;
  localparam int COUNTER_WIDTH = 32;

  localparam int ADDR_W    = 16;
  localparam int PAGE_W    = 8;
  localparam int OFFSET_W  = 8;
  localparam int OUT_CNT_W = 32;
  localparam int SLOT_W    = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
  localparam int MAP_W     = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;

  localparam logic [PAGE_W:0]        PAGE_LIMIT  = (PAGE_W + 1)'(PAGE_COUNT);
  localparam logic [OUT_CNT_W-1:0]   OUT_CNT_MAX = {OUT_CNT_W{1'b1}};

  typedef enum logic [1:0] {
    OUTCOME_TLB_HIT  = 2'd0,
    OUTCOME_PAGE_HIT = 2'd1,
    OUTCOME_FAULT    = 2'd2
  } outcome_e;

  // per-cell update command
  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctl_t;

  // counter increments for one committed transaction
  typedef struct packed {
    logic address;
    logic tlb_hit;
    logic page_hit;
    logic fault;
  } cnt_inc_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] tlb_hit;
    logic [OUT_CNT_W-1:0] page_hit;
    logic [OUT_CNT_W-1:0] fault;
    logic [OUT_CNT_W-1:0] address;
  } totals_t;

  function automatic logic [COUNTER_WIDTH-1:0] cnt_bump(
    logic [COUNTER_WIDTH-1:0] c,
    logic                     en
  );
    logic [COUNTER_WIDTH-1:0] r;
    r = c;
    if (en && (c != {COUNTER_WIDTH{1'b1}})) begin
      r = c + 1'b1;
    end
    return r;
  endfunction

  // clamp a counter into the reported field width
  function automatic logic [OUT_CNT_W-1:0] cnt_report(logic [COUNTER_WIDTH-1:0] c);
    logic [63:0] w;
    w = 64'(c);
    return (w > 64'(OUT_CNT_MAX)) ? OUT_CNT_MAX : w[OUT_CNT_W-1:0];
  endfunction

endpackage

>>> rtl/tlbpt_if.sv
// handshake channels: address in, translation result out
interface tlbpt_addr_if import tlbpt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink   (input valid, input logical_address, output ready);
endinterface

interface tlbpt_res_if import tlbpt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PAGE_W-1:0]    page_number;
  logic [OFFSET_W-1:0]  addr_offset;
  logic [1:0]           outcome;
  logic [OUT_CNT_W-1:0] tlb_hit_total;
  logic [OUT_CNT_W-1:0] page_hit_total;
  logic [OUT_CNT_W-1:0] fault_total;
  logic [OUT_CNT_W-1:0] address_total;

  modport source (
    output valid, output page_number, output addr_offset, output outcome,
    output tlb_hit_total, output page_hit_total, output fault_total,
    output address_total, input ready
  );
  modport sink (
    input valid, input page_number, input addr_offset, input outcome,
    input tlb_hit_total, input page_hit_total, input fault_total,
    input address_total, output ready
  );
endinterface

>>> rtl/tlbpt_cell.sv
// one tlb entry: tag and valid bit, compare, load or take from the neighbour
module tlbpt_cell import tlbpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [PAGE_W-1:0] page_i,
  input  logic [PAGE_W-1:0] prev_tag_i,
  input  logic              prev_valid_i,
  output logic [PAGE_W-1:0] tag_o,
  output logic              valid_o,
  output logic              match_o
);

  logic [PAGE_W-1:0] tag_q;
  logic              valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q   <= '0;
      valid_q <= 1'b0;
    end else if (ctl_i.load) begin
      tag_q   <= page_i;
      valid_q <= 1'b1;
    end else if (ctl_i.shift) begin
      tag_q   <= prev_tag_i;
      valid_q <= prev_valid_i;
    end
  end

  assign tag_o   = tag_q;
  assign valid_o = valid_q;
  assign match_o = valid_q && (tag_q == page_i);

endmodule

>>> rtl/tlbpt_counters.sv
// four saturating event counters and their clamped report values
module tlbpt_counters import tlbpt_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cnt_inc_t inc_i,
  output totals_t  totals_o
);

  logic [COUNTER_WIDTH-1:0] tlb_hit_q, tlb_hit_d;
  logic [COUNTER_WIDTH-1:0] page_hit_q, page_hit_d;
  logic [COUNTER_WIDTH-1:0] fault_q, fault_d;
  logic [COUNTER_WIDTH-1:0] address_q, address_d;

  always_comb begin
    tlb_hit_d  = cnt_bump(tlb_hit_q, inc_i.tlb_hit);
    page_hit_d = cnt_bump(page_hit_q, inc_i.page_hit);
    fault_d    = cnt_bump(fault_q, inc_i.fault);
    address_d  = cnt_bump(address_q, inc_i.address);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tlb_hit_q  <= '0;
      page_hit_q <= '0;
      fault_q    <= '0;
      address_q  <= '0;
    end else begin
      tlb_hit_q  <= tlb_hit_d;
      page_hit_q <= page_hit_d;
      fault_q    <= fault_d;
      address_q  <= address_d;
    end
  end

  // values after this transaction
  assign totals_o.tlb_hit  = cnt_report(tlb_hit_d);
  assign totals_o.page_hit = cnt_report(page_hit_d);
  assign totals_o.fault    = cnt_report(fault_d);
  assign totals_o.address  = cnt_report(address_d);

endmodule

>>> rtl/tlb_fifo_lru_page_tracker.sv
// top level: address register, row of tlb cells, residency map, result register
// an accepted address waits in the address register, then its result goes to the
// result register once that is free; throughput: one address per cycle while the
// output is not stalled; tag compare, map read and cell update all act on commit
// reset: asynchronous, clears all cells to invalid, the residency map, fifo
// pointer, counters and mode (fifo); no clearing pass, ready right after reset
module tlb_fifo_lru_page_tracker import tlbpt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  tlbpt_addr_if.sink        addr_in,
  tlbpt_res_if.source       res_out
);

`include "tlb_fifo_lru_page_tracker_defines.svh"

  logic                  mode_q;
  logic                  busy_q;
  logic [ADDR_W-1:0]     addr_q;
  logic [SLOT_W-1:0]     fifo_slot_q;
  logic [PAGE_COUNT-1:0] map_q;

  logic                  out_valid_q;
  logic [PAGE_W-1:0]     page_number_q;
  logic [OFFSET_W-1:0]   addr_offset_q;
  outcome_e              outcome_q;
  totals_t               totals_q;

  logic [PAGE_W-1:0]     page;
  logic [OFFSET_W-1:0]   offset;
  logic [MAP_W-1:0]      map_idx;
  logic                  in_map;
  logic                  resident;
  logic                  out_free;
  logic                  commit;
  logic                  accept;
  logic                  tlb_hit;
  logic                  page_hit;
  logic                  fault;
  logic [SLOT_W-1:0]     hit_pos;
  outcome_e              outcome;

  logic [TLB_ENTRIES-1:0] cell_match;
  logic [TLB_ENTRIES-1:0] cell_valid;
  logic [PAGE_W-1:0]      cell_tag [TLB_ENTRIES];
  cell_ctl_t              cell_ctl [TLB_ENTRIES];

  cnt_inc_t inc;
  totals_t  totals;

  assign page    = addr_q[ADDR_W-1:OFFSET_W];
  assign offset  = addr_q[OFFSET_W-1:0];
  assign map_idx = page[MAP_W-1:0];
  assign in_map  = {1'b0, page} < PAGE_LIMIT;

  assign out_free = !out_valid_q || res_out.ready;
  assign commit   = busy_q && out_free;
  assign addr_in.ready = !busy_q || out_free;
  assign accept   = addr_in.valid && addr_in.ready;

  // lowest matching entry wins
  always_comb begin
    tlb_hit = 1'b0;
    hit_pos = '0;
    for (int i = TLB_ENTRIES - 1; i >= 0; i--) begin
      if (cell_match[i]) begin
        tlb_hit = 1'b1;
        hit_pos = SLOT_W'(i);
      end
    end
  end

  assign resident = in_map && map_q[map_idx];
  assign page_hit = !tlb_hit && resident;
  assign fault    = !tlb_hit && !resident;

  always_comb begin
    if (tlb_hit) begin
      outcome = OUTCOME_TLB_HIT;
    end else if (resident) begin
      outcome = OUTCOME_PAGE_HIT;
    end else begin
      outcome = OUTCOME_FAULT;
    end
  end

  for (genvar i = 0; i < TLB_ENTRIES; i++) begin : g_cell
    logic [PAGE_W-1:0] prev_tag;
    logic              prev_valid;

    // the front cell takes the current page when the row shifts
    if (i == 0) begin : g_front
      assign prev_tag   = page;
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_tag   = cell_tag[i-1];
      assign prev_valid = cell_valid[i-1];
    end

    assign cell_ctl[i].shift = commit && mode_q &&
                               (tlb_hit ? (SLOT_W'(i) <= hit_pos) : fault);
    assign cell_ctl[i].load  = commit && !mode_q && fault &&
                               (fifo_slot_q == SLOT_W'(i));

    tlbpt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (cell_ctl[i]),
      .page_i       (page),
      .prev_tag_i   (prev_tag),
      .prev_valid_i (prev_valid),
      .tag_o        (cell_tag[i]),
      .valid_o      (cell_valid[i]),
      .match_o      (cell_match[i])
    );
  end

  assign inc.address  = commit;
  assign inc.tlb_hit  = commit && tlb_hit;
  assign inc.page_hit = commit && page_hit;
  assign inc.fault    = commit && fault;

  tlbpt_counters u_counters (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .inc_i    (inc),
    .totals_o (totals)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= 1'b0;
      busy_q      <= 1'b0;
      fifo_slot_q <= '0;
      map_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (commit) begin
        busy_q <= 1'b0;
      end
      if (commit && fault && in_map) begin
        map_q[map_idx] <= 1'b1;
      end
      if (commit && fault && !mode_q) begin
        fifo_slot_q <= (fifo_slot_q == SLOT_W'(TLB_ENTRIES - 1)) ? '0
                                                                 : fifo_slot_q + 1'b1;
      end
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (res_out.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      addr_q <= addr_in.logical_address;
    end
    if (commit) begin
      page_number_q <= page;
      addr_offset_q <= offset;
      outcome_q     <= outcome;
      totals_q      <= totals;
    end
  end

  assign res_out.valid          = out_valid_q;
  assign res_out.page_number    = page_number_q;
  assign res_out.addr_offset    = addr_offset_q;
  assign res_out.outcome        = outcome_q;
  assign res_out.tlb_hit_total  = totals_q.tlb_hit;
  assign res_out.page_hit_total = totals_q.page_hit;
  assign res_out.fault_total    = totals_q.fault;
  assign res_out.address_total  = totals_q.address;

  `TLBPT_ASSERT_IMP(a_one_outcome, busy_q, $onehot({tlb_hit, page_hit, fault}),
    "lookup must give exactly one outcome")
  `TLBPT_ASSERT_NXT(a_fault_marks_map, commit && fault && in_map, map_q[$past(map_idx)],
    "faulting page not marked resident")
  `TLBPT_ASSERT_NXT(a_lru_front, commit && mode_q && !page_hit,
    cell_valid[0] && (cell_tag[0] == $past(page)),
    "lru update did not put the page at the front")
  `TLBPT_ASSERT_NXT(a_stall_holds, busy_q && !out_free, busy_q && $stable(addr_q),
    "pending address lost while result stalled")
  `TLBPT_ASSERT_NXT(a_commit_shows, commit, out_valid_q,
    "committed transaction produced no result")

endmodule
